@@ hw/rtl/ntsc_pkg.sv @@
// Shared types and constants for the number-to-speech clip sequencer.
// No dependencies; imported by every module of the block.
package ntsc_pkg;

  localparam int NumSlots = 10;
  localparam int ClipW    = 8;
  localparam int MagW     = 20;
  localparam int GrpW     = 10;

  localparam logic signed [31:0] MaxMag = 32'sd999999;

  // floor(2^30 / 1000); the quotient may come out one low and is corrected
  localparam logic [20:0] Recip1000 = 21'd1073741;
  localparam logic [7:0]  CompoundBase = 8'd200;
  localparam logic [7:0]  TeenBase     = 8'd10;

  typedef enum logic [2:0] {
    CfgCompound = 3'd0,
    CfgZero     = 3'd1,
    CfgMinus    = 3'd2,
    CfgHundred  = 3'd3,
    CfgThousand = 3'd4
  } ntsc_cfg_idx_t;

  // spoken order of the clip slots
  localparam int SlotLead     = 0;
  localparam int SlotHthDigit = 1;
  localparam int SlotHthWord  = 2;
  localparam int SlotThTens   = 3;
  localparam int SlotThUnits  = 4;
  localparam int SlotThWord   = 5;
  localparam int SlotHDigit   = 6;
  localparam int SlotHWord    = 7;
  localparam int SlotTens     = 8;
  localparam int SlotUnits    = 9;

  typedef struct packed {
    logic       compound;
    logic [7:0] zero_clip;
    logic [7:0] minus_clip;
    logic [7:0] hundred_clip;
    logic [7:0] thousand_clip;
  } ntsc_cfg_t;

  typedef struct packed {
    logic       neg;
    logic       oor;
    logic       zero;
    logic       hi_nz;
    logic [3:0] d5;
    logic [3:0] d4;
    logic [3:0] d3;
    logic [3:0] d2;
    logic [3:0] d1;
    logic [3:0] d0;
  } ntsc_digits_t;

  typedef struct packed {
    logic                               oor;
    logic [NumSlots-1:0]                mask;
    logic [NumSlots-1:0][ClipW-1:0]     clips;
  } ntsc_plan_t;

endpackage

@@ hw/rtl/number_to_speech_clip_sequencer_unit.sv @@
// Top level of the number-to-speech clip sequencer: config registers and pipeline.
// Depends on ntsc_pkg, ntsc_split, ntsc_plan and ntsc_emit.
//
// Input channel (in_valid/in_ready/number) takes one signed 32-bit word per
// cycle while in_ready is high. Output channel (out_valid/out_ready) returns
// the clips that say it, one word per cycle while out_ready is high, with last
// on the final clip. A value beyond +/-999999 returns one word: clip 0, last
// and out_of_range set. Config port (cfg_we/cfg_index/cfg_data) writes a register;
// indexes beyond the five registers are dropped. Write only while idle.
// A number passes the five split stages and the plan register; the serializer
// then registers its first clip. Throughput: one clip per cycle while out_ready
// is high; a number gives 1 to 10 clips, paced by the single serializer. Six
// register stages ahead of it take a new number every cycle while they have room.
// Reset clears the config registers to 0 and empties the pipeline; data registers are not reset.
// A stall on out_ready holds the output word; the serializer and pipeline
// stages back up in turn and in_ready drops once all are full.
module number_to_speech_clip_sequencer_unit import ntsc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  clip,
  output logic        last,
  output logic        out_of_range,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  ntsc_cfg_t    cfg;
  ntsc_digits_t dig;
  ntsc_plan_t   plan;
  logic         dig_valid, dig_ready, plan_valid, plan_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgCompound: cfg.compound      <= cfg_data[0];
        CfgZero:     cfg.zero_clip     <= cfg_data;
        CfgMinus:    cfg.minus_clip    <= cfg_data;
        CfgHundred:  cfg.hundred_clip  <= cfg_data;
        CfgThousand: cfg.thousand_clip <= cfg_data;
        default: ;
      endcase
    end
  end

  ntsc_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .number    (number),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig       (dig)
  );

  ntsc_plan u_plan (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .dig_valid  (dig_valid),
    .dig_ready  (dig_ready),
    .dig        (dig),
    .plan_valid (plan_valid),
    .plan_ready (plan_ready),
    .plan       (plan)
  );

  ntsc_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .plan_valid   (plan_valid),
    .plan_ready   (plan_ready),
    .plan         (plan),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .clip         (clip),
    .last         (last),
    .out_of_range (out_of_range)
  );

endmodule

@@ hw/rtl/ntsc_split.sv @@
// Five-stage pipeline: sign, range check and magnitude, then decimal digits.
// Depends on ntsc_pkg.
module ntsc_split import ntsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        number,
  output logic               dig_valid,
  input  logic               dig_ready,
  output ntsc_digits_t       dig
);

  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5 || dig_ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready  = rdy1;
  assign dig_valid = v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // stage 1: sign, range, magnitude
  logic signed [31:0] num_s;
  logic [31:0]        abs0;
  logic               neg1, oor1, zero1;
  logic [MagW-1:0]    mag1;

  assign num_s = number;
  assign abs0  = number[31] ? (~number + 32'd1) : number;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      neg1  <= number[31];
      oor1  <= (num_s > MaxMag) || (num_s < -MaxMag);
      zero1 <= (number == 32'd0);
      mag1  <= abs0[MagW-1:0];
    end
  end

  // stage 2: approximate quotient by 1000
  logic [40:0]     prod2;
  logic            neg2, oor2, zero2;
  logic [MagW-1:0] mag2;
  logic [GrpW-1:0] q2;

  assign prod2 = 41'(mag1) * 41'(Recip1000);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      neg2  <= neg1;
      oor2  <= oor1;
      zero2 <= zero1;
      mag2  <= mag1;
      q2    <= prod2[39:30];
    end
  end

  // stage 3: correct quotient, split into thousands and low groups
  logic [MagW-1:0] qk3, rem3;
  logic            ge3;
  logic            neg3, oor3, zero3, hinz3;
  logic [GrpW-1:0] hi3, lo3;

  assign qk3  = MagW'(q2) * 20'd1000;
  assign rem3 = mag2 - qk3;
  assign ge3  = (rem3 >= 20'd1000);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      neg3  <= neg2;
      oor3  <= oor2;
      zero3 <= zero2;
      hi3   <= ge3 ? q2 + 10'd1 : q2;
      lo3   <= ge3 ? GrpW'(rem3 - 20'd1000) : rem3[GrpW-1:0];
      hinz3 <= ge3 || (q2 != 10'd0);
    end
  end

  // stage 4: hundreds digit of each group, x/100 == (x*41)>>12 for x < 1000
  logic [15:0] ph4, pl4;
  logic [3:0]  hh4, hl4;
  logic [6:0]  rh4, rl4;
  logic        neg4, oor4, zero4, hinz4;

  assign ph4 = 16'(hi3) * 16'd41;
  assign pl4 = 16'(lo3) * 16'd41;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      neg4  <= neg3;
      oor4  <= oor3;
      zero4 <= zero3;
      hinz4 <= hinz3;
      hh4   <= ph4[15:12];
      hl4   <= pl4[15:12];
      rh4   <= 7'(hi3 - GrpW'(ph4[15:12]) * 10'd100);
      rl4   <= 7'(lo3 - GrpW'(pl4[15:12]) * 10'd100);
    end
  end

  // stage 5: tens and units, x/10 == (x*205)>>11 for x < 100
  logic [14:0] pth5, ptl5;

  assign pth5 = 15'(rh4) * 15'd205;
  assign ptl5 = 15'(rl4) * 15'd205;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      dig.neg   <= neg4;
      dig.oor   <= oor4;
      dig.zero  <= zero4;
      dig.hi_nz <= hinz4;
      dig.d5    <= hh4;
      dig.d4    <= pth5[14:11];
      dig.d3    <= 4'(rh4 - 7'(pth5[14:11]) * 7'd10);
      dig.d2    <= hl4;
      dig.d1    <= ptl5[14:11];
      dig.d0    <= 4'(rl4 - 7'(ptl5[14:11]) * 7'd10);
    end
  end

endmodule

@@ hw/rtl/ntsc_plan.sv @@
// Pipeline stage that maps six digits onto the ten clip slots and their enables.
// Depends on ntsc_pkg.
module ntsc_plan import ntsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  ntsc_cfg_t    cfg,
  input  logic         dig_valid,
  output logic         dig_ready,
  input  ntsc_digits_t dig,
  output logic         plan_valid,
  input  logic         plan_ready,
  output ntsc_plan_t   plan
);

  ntsc_plan_t nxt;
  logic       active;

  assign dig_ready = !plan_valid || plan_ready;

  always_comb begin
    active = !dig.oor && !dig.zero;
    nxt.oor = dig.oor;
    nxt.mask = '0;
    nxt.clips = '0;

    nxt.mask[SlotLead]  = dig.oor || dig.zero || dig.neg;
    nxt.clips[SlotLead] = dig.oor ? 8'd0 : (dig.zero ? cfg.zero_clip : cfg.minus_clip);

    nxt.mask[SlotHthDigit]  = active && (dig.d5 != 4'd0);
    nxt.clips[SlotHthDigit] = cfg.compound ? CompoundBase + 8'(dig.d5) : 8'(dig.d5);
    nxt.mask[SlotHthWord]   = active && (dig.d5 != 4'd0) && !cfg.compound;
    nxt.clips[SlotHthWord]  = cfg.hundred_clip;

    nxt.mask[SlotThTens]  = active && dig.hi_nz && (dig.d4 != 4'd0);
    nxt.clips[SlotThTens] = (dig.d4 == 4'd1) ? TeenBase + 8'(dig.d3)
                                              : 8'({dig.d4, 3'b000}) + 8'({dig.d4, 1'b0});
    nxt.mask[SlotThUnits]  = active && dig.hi_nz && (dig.d4 != 4'd1) && (dig.d3 != 4'd0);
    nxt.clips[SlotThUnits] = 8'(dig.d3);
    nxt.mask[SlotThWord]   = active && dig.hi_nz;
    nxt.clips[SlotThWord]  = cfg.thousand_clip;

    nxt.mask[SlotHDigit]  = active && (dig.d2 != 4'd0);
    nxt.clips[SlotHDigit] = cfg.compound ? CompoundBase + 8'(dig.d2) : 8'(dig.d2);
    nxt.mask[SlotHWord]   = active && (dig.d2 != 4'd0) && !cfg.compound;
    nxt.clips[SlotHWord]  = cfg.hundred_clip;

    nxt.mask[SlotTens]  = active && (dig.d1 != 4'd0);
    nxt.clips[SlotTens] = (dig.d1 == 4'd1) ? TeenBase + 8'(dig.d0)
                                            : 8'({dig.d1, 3'b000}) + 8'({dig.d1, 1'b0});
    nxt.mask[SlotUnits]  = active && (dig.d1 != 4'd1) && (dig.d0 != 4'd0);
    nxt.clips[SlotUnits] = 8'(dig.d0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plan_valid <= 1'b0;
    end else if (dig_ready) begin
      plan_valid <= dig_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_ready) begin
      plan <= nxt;
    end
  end

endmodule

@@ hw/rtl/ntsc_emit.sv @@
// Output serializer: walks the enabled slots of one plan, one word per cycle while out_ready is high.
// Depends on ntsc_pkg.
module ntsc_emit import ntsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             plan_valid,
  output logic             plan_ready,
  input  ntsc_plan_t       plan,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ClipW-1:0] clip,
  output logic             last,
  output logic             out_of_range
);

  logic [NumSlots-1:0]            mask, low, mask_after;
  logic [NumSlots-1:0][ClipW-1:0] clips;
  logic                           oor;
  logic                           out_free, step, load;
  logic [ClipW-1:0]               sel;

  assign out_free   = !out_valid || out_ready;
  assign step       = out_free && (mask != '0);
  assign low        = mask & (~mask + NumSlots'(1));
  assign mask_after = step ? (mask & ~low) : mask;
  assign plan_ready = (mask_after == '0);
  assign load       = plan_valid && plan_ready;

  always_comb begin
    sel = '0;
    for (int i = 0; i < NumSlots; i++) begin
      sel = sel | (clips[i] & {ClipW{low[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      mask <= load ? plan.mask : mask_after;
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      clips <= plan.clips;
      oor   <= plan.oor;
    end
    if (step) begin
      clip         <= sel;
      last         <= ((mask & ~low) == '0);
      out_of_range <= oor;
    end
  end

endmodule

@@ sim/tb_number_to_speech_clip_sequencer_unit.sv @@
`timescale 1ns / 100ps
// Testbench for number_to_speech_clip_sequencer_unit: directed table, then random phases
// under several register settings; each word checked against a typed or predicted word.
// Depends on ntsc_pkg and the sequencer RTL.
module tb_number_to_speech_clip_sequencer_unit;
  import ntsc_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int ItemsPerPhase = 20;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [7:0] clip;
    logic       last;
    logic       oor;
  } clip_word_t;

  typedef struct {
    logic [31:0] num;
    bit          typed;
    logic [7:0]  clip;
    logic        oor;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  clip;
  logic        last;
  logic        out_of_range;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  ntsc_cfg_t   cfg_shadow = '0;
  clip_word_t  clips_due[$];
  clip_word_t  spoken[$];
  int          errors = 0;
  int          cycles = 0;
  logic        idle_on = 1'b1;
  logic        hold_req = 1'b0;
  logic        hold_taken = 1'b0;
  int          hold_left = 0;
  logic [7:0]  setting [4][5];

  stim_row_t dir_rows [24] = '{
    '{32'd0,          1'b1, 8'd0, 1'b0},
    '{32'd7,          1'b1, 8'd7, 1'b0},
    '{32'd9,          1'b0, 8'd0, 1'b0},
    '{32'd10,         1'b0, 8'd0, 1'b0},
    '{32'd11,         1'b0, 8'd0, 1'b0},
    '{32'd19,         1'b0, 8'd0, 1'b0},
    '{32'd20,         1'b0, 8'd0, 1'b0},
    '{32'd21,         1'b0, 8'd0, 1'b0},
    '{32'd99,         1'b0, 8'd0, 1'b0},
    '{32'd100,        1'b0, 8'd0, 1'b0},
    '{32'd101,        1'b0, 8'd0, 1'b0},
    '{32'd110,        1'b0, 8'd0, 1'b0},
    '{32'd999,        1'b0, 8'd0, 1'b0},
    '{32'd1000,       1'b0, 8'd0, 1'b0},
    '{32'd1001,       1'b0, 8'd0, 1'b0},
    '{32'd20000,      1'b0, 8'd0, 1'b0},
    '{32'd100000,     1'b0, 8'd0, 1'b0},
    '{32'd999999,     1'b0, 8'd0, 1'b0},
    '{-32'sd1,        1'b0, 8'd0, 1'b0},
    '{-32'sd999999,   1'b0, 8'd0, 1'b0},
    '{32'd1000000,    1'b1, 8'd0, 1'b1},
    '{-32'sd1000000,  1'b1, 8'd0, 1'b1},
    '{32'h7FFFFFFF,   1'b1, 8'd0, 1'b1},
    '{32'h80000000,   1'b1, 8'd0, 1'b1}
  };

  number_to_speech_clip_sequencer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .number       (number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .clip         (clip),
    .last         (last),
    .out_of_range (out_of_range),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    errors++;
  endtask

  function automatic void add_clip(input logic [7:0] c);
    spoken.push_back('{c, 1'b0, 1'b0});
  endfunction

  function automatic void say_pair(input int unsigned tens, input int unsigned units);
    if (tens == 0) begin
      if (units != 0) add_clip(8'(units));
    end else if (tens == 1) begin
      add_clip(TeenBase + 8'(units));
    end else begin
      add_clip(8'(10 * tens));
      if (units != 0) add_clip(8'(units));
    end
  endfunction

  function automatic void say_hundreds(input int unsigned d);
    if (d != 0) begin
      if (cfg_shadow.compound) begin
        add_clip(CompoundBase + 8'(d));
      end else begin
        add_clip(8'(d));
        add_clip(cfg_shadow.hundred_clip);
      end
    end
  endfunction

  // builds the spoken clip sequence for one number and queues it
  function automatic void predict_clips(input logic [31:0] num);
    int          v;
    int unsigned mag;
    int unsigned dg [6];
    int          top;
    v = $signed(num);
    top = 0;
    spoken.delete();
    if (v > MaxMag || v < -MaxMag) begin
      spoken.push_back('{8'd0, 1'b0, 1'b1});
    end else if (v == 0) begin
      add_clip(cfg_shadow.zero_clip);
    end else begin
      if (v < 0) begin
        add_clip(cfg_shadow.minus_clip);
        v = -v;
      end
      mag = v;
      for (int i = 0; i < 6; i++) begin
        dg[i] = mag % 10;
        mag = mag / 10;
        if (dg[i] != 0) top = i;
      end
      if (top >= 5) say_hundreds(dg[5]);
      if (top >= 3) begin
        say_pair(dg[4], dg[3]);
        add_clip(cfg_shadow.thousand_clip);
      end
      if (top >= 2) say_hundreds(dg[2]);
      say_pair(dg[1], dg[0]);
    end
    spoken[spoken.size() - 1].last = 1'b1;
    foreach (spoken[i]) clips_due.push_back(spoken[i]);
  endfunction

  function automatic logic [31:0] pick_number();
    int unsigned pick;
    int unsigned mag;
    pick = $urandom_range(99);
    if (pick < 8) return $urandom;
    if (pick < 14) begin
      case ($urandom_range(6))
        0: return 32'd999999;
        1: return -32'sd999999;
        2: return 32'd1000000;
        3: return -32'sd1000000;
        4: return 32'd0;
        5: return 32'h80000000;
        default: return 32'h7FFFFFFF;
      endcase
    end
    if (pick < 40) begin
      mag = $urandom_range(999);
    end else if (pick < 65) begin
      mag = $urandom_range(999999);
    end else begin
      // sparse digits so that zero groups and zero hundreds come up often
      mag = 0;
      for (int i = 0; i < 6; i++)
        mag = mag * 10 + ($urandom_range(1) ? $urandom_range(9) : 0);
    end
    return $urandom_range(1) ? 32'(-int'(mag)) : 32'(mag);
  endfunction

  task automatic send_number(input logic [31:0] num);
    bit took;
    if (idle_on) begin
      while ($urandom_range(99) < 10) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    number <= num;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CfgCompound: cfg_shadow.compound = data[0];
      CfgZero:     cfg_shadow.zero_clip = data;
      CfgMinus:    cfg_shadow.minus_clip = data;
      CfgHundred:  cfg_shadow.hundred_clip = data;
      CfgThousand: cfg_shadow.thousand_clip = data;
      default: ;
    endcase
  endtask

  task automatic drain_phase();
    in_valid <= 1'b0;
    while (clips_due.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HoldCycles;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 10);
    end
  end

  always @(negedge clk) begin
    clip_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (clips_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word clip=%0d last=%b oor=%b",
                                  clip, last, out_of_range));
      end else begin
        want = clips_due.pop_front();
        if (clip !== want.clip)
          report_mismatch($sformatf("clip %0d, want %0d", clip, want.clip));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, want %b", last, want.last));
        if (out_of_range !== want.oor)
          report_mismatch($sformatf("out_of_range %b, want %b", out_of_range, want.oor));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    setting = '{
      '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF},
      '{8'hFE, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h01, 8'h3C, 8'hC3, 8'h81, 8'h7E},
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };
    for (int r = 0; r < 5; r++) setting[3][r] = 8'($urandom);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: digit mode, every clip register zero
    foreach (dir_rows[i]) begin
      send_number(dir_rows[i].num);
      if (dir_rows[i].typed)
        clips_due.push_back('{dir_rows[i].clip, 1'b1, dir_rows[i].oor});
      else
        predict_clips(dir_rows[i].num);
    end
    drain_phase();

    for (int p = 0; p < 4; p++) begin
      for (int r = CfgCompound; r <= CfgThousand; r++)
        cfg_write(3'(r), setting[p][r]);
      if (p == 1) begin
        for (int r = CfgThousand + 1; r < 8; r++)
          cfg_write(3'(r), 8'($urandom));
      end
      @(posedge clk);
      cfg_we <= 1'b0;
      idle_on <= (p != 1);
      hold_req <= (p == 0) || hold_req;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        logic [31:0] num;
        num = pick_number();
        send_number(num);
        predict_clips(num);
      end
      drain_phase();
    end

    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
